>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; defining ASSERT_OFF strips them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/cvms_pkg.sv
// ----------------------------------------------------------------------------
// cvms_pkg
// shared constants, types and helpers of the control value to midi scaler
// ----------------------------------------------------------------------------
package cvms_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 18;
  localparam int ROOT_FRAC  = 20;
  localparam int ROOT_BITS  = ROOT_FRAC + 1;
  localparam int CUBE_W     = 3 * ROOT_BITS;
  localparam int ROOT_SHIFT = 3 * ROOT_FRAC - FRAC_BITS;
  localparam int MAG_W      = FRAC_BITS + 1;
  localparam int SQ_W       = 2 * ROOT_BITS;
  localparam int REM_W      = 2 * ROOT_BITS + 6;
  localparam int Q_W        = (ROOT_FRAC > FRAC_BITS) ? ROOT_FRAC + 1 : FRAC_BITS + 1;
  localparam int P_W        = Q_W + 1;
  localparam int LEVEL_W    = 14;
  localparam int LEVEL7_W   = 7;
  localparam int PROD_W     = P_W + LEVEL_W;
  localparam int KIND_W     = 4;
  localparam int CHAN_W     = 4;
  localparam int NUM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [LEVEL_W-1:0] SCALE7  = 14'h007f;
  localparam logic [LEVEL_W-1:0] SCALE14 = 14'h3fff;

  localparam logic [KIND_W-1:0] KIND_CONTROLLER = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PITCH_BEND = 4'd6;
  localparam logic [KIND_W-1:0] KIND_NRPN       = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVENT_KIND,
    REG_MIDI_CHANNEL,
    REG_CONTROLLER_NUMBER,
    REG_LOG_MODE,
    REG_INVERT_MODE,
    REG_BIPOLAR_MODE,
    REG_OUTPUT_ENABLE
  } cfg_reg_t;

  // operand carried down the cube root pipeline
  typedef struct packed {
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [CUBE_W-1:0]    pend;
    logic [REM_W-1:0]     rem;
    logic [ROOT_BITS-1:0] root;
    logic [SQ_W-1:0]      sq;
  } root_t;

  typedef struct packed {
    logic log_on;
    logic bipolar;
    logic invert;
    logic wide;
  } mode_t;

  // pitch bend, ctl14, rpn and nrpn use the 14-bit range
  function automatic logic is_wide(input logic [KIND_W-1:0] kind);
    return (kind >= KIND_PITCH_BEND) && (kind <= KIND_NRPN);
  endfunction

endpackage

>>> rtl/core/cvms_front.sv
// ----------------------------------------------------------------------------
// cvms_front
// input stage: range clamp, sign split and root operand set-up
// ----------------------------------------------------------------------------
module cvms_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 bipolar,
  input  logic                                 enable,
  input  logic                                 up_valid,
  input  logic signed [cvms_pkg::IN_W-1:0]     control_value,
  output logic                                 up_ready,
  output logic                                 dn_valid,
  output cvms_pkg::root_t                      dn_data,
  input  logic                                 dn_ready
);

  localparam int X_W = (cvms_pkg::IN_W > cvms_pkg::FRAC_BITS + 2) ?
                       cvms_pkg::IN_W : cvms_pkg::FRAC_BITS + 2;
  localparam logic signed [X_W-1:0] ONE =
    {{(X_W - cvms_pkg::FRAC_BITS - 1){1'b0}}, 1'b1, {cvms_pkg::FRAC_BITS{1'b0}}};
  localparam logic signed [X_W-1:0] NEG_ONE = -ONE;

  logic signed [X_W-1:0] xs;
  logic signed [X_W-1:0] xc;
  logic [X_W-1:0]        absx;
  logic                  adv;
  cvms_pkg::root_t       data_next;

  assign adv      = !dn_valid || dn_ready;
  assign up_ready = adv;

  always_comb begin
    xs = X_W'(control_value);
    if (xs > ONE) begin
      xc = ONE;
    end else if (bipolar && (xs < NEG_ONE)) begin
      xc = NEG_ONE;
    end else if (!bipolar && (xs < 0)) begin
      xc = '0;
    end else begin
      xc = xs;
    end
    absx = (xc < 0) ? X_W'(-xc) : X_W'(xc);
    data_next.neg  = (xc < 0);
    data_next.mag  = absx[cvms_pkg::MAG_W-1:0];
    data_next.pend = cvms_pkg::CUBE_W'(data_next.mag) << cvms_pkg::ROOT_SHIFT;
    data_next.rem  = '0;
    data_next.root = '0;
    data_next.sq   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid && enable;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_data <= data_next;
    end
  end

endmodule

>>> rtl/core/cvms_root_stage.sv
// ----------------------------------------------------------------------------
// cvms_root_stage
// one restoring cube root step: three radicand bits in, one root bit out
// ----------------------------------------------------------------------------
module cvms_root_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  cvms_pkg::root_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output cvms_pkg::root_t dn_data,
  input  logic            dn_ready
);

  logic                          adv;
  logic [cvms_pkg::REM_W-1:0]    rem_sh;
  logic [cvms_pkg::REM_W-1:0]    trial;
  logic [cvms_pkg::REM_W-1:0]    sq_w;
  logic [cvms_pkg::REM_W-1:0]    root_w;
  logic                          take;
  cvms_pkg::root_t               data_next;

  assign adv      = !dn_valid || dn_ready;
  assign up_ready = adv;

  always_comb begin
    rem_sh = {up_data.rem[cvms_pkg::REM_W-4:0], up_data.pend[cvms_pkg::CUBE_W-1 -: 3]};
    sq_w   = cvms_pkg::REM_W'(up_data.sq);
    root_w = cvms_pkg::REM_W'(up_data.root);
    // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
    trial  = (sq_w << 3) + (sq_w << 2) + (root_w << 2) + (root_w << 1) +
             cvms_pkg::REM_W'(1);
    take   = (rem_sh >= trial);

    data_next      = up_data;
    data_next.pend = up_data.pend << 3;
    if (take) begin
      data_next.rem  = rem_sh - trial;
      data_next.root = {up_data.root[cvms_pkg::ROOT_BITS-2:0], 1'b1};
      data_next.sq   = (up_data.sq << 2) + (cvms_pkg::SQ_W'(up_data.root) << 2) +
                       cvms_pkg::SQ_W'(1);
    end else begin
      data_next.rem  = rem_sh;
      data_next.root = {up_data.root[cvms_pkg::ROOT_BITS-2:0], 1'b0};
      data_next.sq   = up_data.sq << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_data <= data_next;
    end
  end

endmodule

>>> rtl/core/cvms_level.sv
// ----------------------------------------------------------------------------
// cvms_level
// curve select and scaling product, then rounding, limit, invert and output
// ----------------------------------------------------------------------------
module cvms_level (
  input  logic                          clk,
  input  logic                          rst,
  input  cvms_pkg::mode_t               mode,
  input  logic                          up_valid,
  input  cvms_pkg::root_t               up_data,
  output logic                          up_ready,
  output logic                          valid,
  input  logic                          stall,
  output logic [cvms_pkg::LEVEL_W-1:0]  level
);

  localparam int WHOLE_W = cvms_pkg::PROD_W - cvms_pkg::Q_W;
  localparam logic [cvms_pkg::Q_W-1:0] HALF = cvms_pkg::Q_W'(1) << (cvms_pkg::Q_W - 1);
  localparam logic [cvms_pkg::P_W-1:0] MID  = cvms_pkg::P_W'(1) << (cvms_pkg::Q_W - 1);

  logic                            prod_valid;
  logic [cvms_pkg::PROD_W-1:0]     prod;
  logic [cvms_pkg::PROD_W-1:0]     prod_next;
  logic [cvms_pkg::P_W-1:0]        p;
  logic [cvms_pkg::P_W-1:0]        offs;
  logic                            prod_adv;
  logic                            out_adv;

  logic [WHOLE_W-1:0]              whole;
  logic [cvms_pkg::Q_W-1:0]        frac;
  logic                            round_up;
  logic [WHOLE_W-1:0]              rounded;
  logic [cvms_pkg::LEVEL_W-1:0]    scale;
  logic [cvms_pkg::LEVEL_W-1:0]    limited;
  logic [cvms_pkg::LEVEL_W-1:0]    level_next;

  assign out_adv  = !valid || !stall;
  assign prod_adv = !prod_valid || out_adv;
  assign up_ready = prod_adv;

  // p holds the unit value with Q_W fraction bits
  always_comb begin
    if (mode.log_on) begin
      offs = cvms_pkg::P_W'(up_data.root) << (cvms_pkg::Q_W - cvms_pkg::ROOT_FRAC - 1);
      if (mode.bipolar) begin
        p = up_data.neg ? (MID - offs) : (MID + offs);
      end else begin
        p = offs << 1;
      end
    end else begin
      offs = cvms_pkg::P_W'(up_data.mag) << (cvms_pkg::Q_W - cvms_pkg::FRAC_BITS - 1);
      if (mode.bipolar) begin
        p = up_data.neg ? (MID - offs) : (MID + offs);
      end else begin
        p = offs << 1;
      end
    end
    // scale is 2^n - 1, so the product is a shift and a subtract
    if (mode.wide) begin
      prod_next = (cvms_pkg::PROD_W'(p) << cvms_pkg::LEVEL_W) - cvms_pkg::PROD_W'(p);
    end else begin
      prod_next = (cvms_pkg::PROD_W'(p) << cvms_pkg::LEVEL7_W) - cvms_pkg::PROD_W'(p);
    end
  end

  always_comb begin
    whole    = prod[cvms_pkg::PROD_W-1:cvms_pkg::Q_W];
    frac     = prod[cvms_pkg::Q_W-1:0];
    round_up = (frac > HALF) || ((frac == HALF) && whole[0]);
    rounded  = whole + WHOLE_W'(round_up);
    scale    = mode.wide ? cvms_pkg::SCALE14 : cvms_pkg::SCALE7;
    if (rounded > WHOLE_W'(scale)) begin
      limited = scale;
    end else begin
      limited = rounded[cvms_pkg::LEVEL_W-1:0];
    end
    level_next = mode.invert ? (scale - limited) : limited;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      if (prod_adv) begin
        prod_valid <= up_valid;
      end
      if (out_adv) begin
        valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv) begin
      prod <= prod_next;
    end
    if (out_adv) begin
      level <= level_next;
    end
  end

endmodule

>>> rtl/core/control_value_to_midi_scaler.sv
// ----------------------------------------------------------------------------
// control_value_to_midi_scaler
// turns a fixed-point parameter value into one midi controller event
// ----------------------------------------------------------------------------
// takes one beat per clock while in_stall is low and gives one event beat
// per accepted value while output_enable is set; with it clear a value is
// taken and dropped. the stages are one input clamp stage, 21 cube root
// stages (one root bit each, the root having 21 bits), one curve and product
// stage and one rounding stage that is also the output register. every stage
// has its own valid bit and moves on when the stage after it is empty or
// moving, so a stalled output only fills the empty slots behind it and the
// input keeps taking beats until the pipe is full. the linear path rides the
// same stages so ordering never changes. configuration writes go straight to
// the registers and are read live by the clamp, curve and rounding stages
// and the event header, so they must only be made with the pipe empty. no
// state is kept between values and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module control_value_to_midi_scaler (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [cvms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cvms_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input beat
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cvms_pkg::IN_W-1:0]      control_value,
  // event beat
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cvms_pkg::KIND_W-1:0]           out_kind,
  output logic [cvms_pkg::CHAN_W-1:0]           out_channel,
  output logic [cvms_pkg::NUM_W-1:0]            out_number,
  output logic [cvms_pkg::LEVEL_W-1:0]          out_level
);

  // configuration registers
  logic [cvms_pkg::KIND_W-1:0] event_kind;
  logic [cvms_pkg::CHAN_W-1:0] midi_channel;
  logic [cvms_pkg::NUM_W-1:0]  controller_number;
  logic                        log_mode;
  logic                        invert_mode;
  logic                        bipolar_mode;
  logic                        output_enable;

  cvms_pkg::mode_t             mode;

  // pipe links: entry 0 is the clamp stage, entry k+1 is root step k
  logic                        root_valid [0:cvms_pkg::ROOT_BITS];
  logic                        root_ready [0:cvms_pkg::ROOT_BITS];
  cvms_pkg::root_t             root_data  [0:cvms_pkg::ROOT_BITS];
  logic                        front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_kind        <= cvms_pkg::KIND_CONTROLLER;
      midi_channel      <= '0;
      controller_number <= '0;
      log_mode          <= 1'b0;
      invert_mode       <= 1'b0;
      bipolar_mode      <= 1'b0;
      output_enable     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvms_pkg::REG_EVENT_KIND:        event_kind        <= cfg_data[cvms_pkg::KIND_W-1:0];
        cvms_pkg::REG_MIDI_CHANNEL:      midi_channel      <= cfg_data[cvms_pkg::CHAN_W-1:0];
        cvms_pkg::REG_CONTROLLER_NUMBER: controller_number <= cfg_data[cvms_pkg::NUM_W-1:0];
        cvms_pkg::REG_LOG_MODE:          log_mode          <= cfg_data[0];
        cvms_pkg::REG_INVERT_MODE:       invert_mode       <= cfg_data[0];
        cvms_pkg::REG_BIPOLAR_MODE:      bipolar_mode      <= cfg_data[0];
        cvms_pkg::REG_OUTPUT_ENABLE:     output_enable     <= cfg_data[0];
        default: begin
          // index beyond the register list: write ignored
        end
      endcase
    end
  end

  always_comb begin
    mode.log_on  = log_mode;
    mode.bipolar = bipolar_mode;
    mode.invert  = invert_mode;
    mode.wide    = cvms_pkg::is_wide(event_kind);
  end

  assign in_stall = !front_ready;

  // clamp to the unit range and split sign and magnitude
  cvms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .bipolar       (bipolar_mode),
    .enable        (output_enable),
    .up_valid      (in_valid),
    .control_value (control_value),
    .up_ready      (front_ready),
    .dn_valid      (root_valid[0]),
    .dn_data       (root_data[0]),
    .dn_ready      (root_ready[0])
  );

  // cube root, most significant root bit first
  for (genvar k = 0; k < cvms_pkg::ROOT_BITS; k++) begin : g_root
    cvms_root_stage u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (root_valid[k]),
      .up_data  (root_data[k]),
      .up_ready (root_ready[k]),
      .dn_valid (root_valid[k+1]),
      .dn_data  (root_data[k+1]),
      .dn_ready (root_ready[k+1])
    );
  end

  // curve, scale, round ties to even, limit and invert
  cvms_level u_level (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .up_valid (root_valid[cvms_pkg::ROOT_BITS]),
    .up_data  (root_data[cvms_pkg::ROOT_BITS]),
    .up_ready (root_ready[cvms_pkg::ROOT_BITS]),
    .valid    (out_valid),
    .stall    (out_stall),
    .level    (out_level)
  );

  // event header = registers; user keeps it stable while busy, unenforced
  assign out_kind    = event_kind;
  assign out_channel = midi_channel;
  assign out_number  = controller_number;

  // level never exceeds the 7-bit range for narrow kinds
  `ASSERT_IMPLY(a_level_in_scale, clk, rst, out_valid && !cvms_pkg::is_wide(out_kind), out_level <= cvms_pkg::SCALE7)
  // the input only stalls while the clamp stage holds a beat
  `ASSERT_IMPLY(a_stall_only_full, clk, rst, in_stall, root_valid[0])
  // a value taken with output disabled never enters the pipe
  `ASSERT_NEXT(a_disabled_dropped, clk, rst, in_valid && !in_stall && !output_enable, !root_valid[0])
  // a held clamp stage keeps its beat
  `ASSERT_NEXT(a_front_held, clk, rst, root_valid[0] && !root_ready[0], root_valid[0])

endmodule
